// ----- hw/rtl/ghi_pkg.sv -----
// ----------------------------------------------------------------------------
// ghi_pkg: shared types and constants of the gyro heading integrator.
// Holds the request command codes, register indexes, controller states and
// the command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ghi_pkg;

	// Field widths of the request and result channels.
	localparam int CMD_W    = 2;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 16;
	localparam int ANGLE_W  = 64;
	localparam int OFFSET_W = 24;
	localparam int CFG_W    = 16;

	// Offset and angle carry this many fraction bits.
	localparam int FRAC_BITS = 8;

	// Calibration sum and the serial divider.
	localparam int SUM_W      = 40;
	localparam int COUNT_W    = 16;
	localparam int DIV_STEPS  = SUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Product of the bias-corrected rate (25 bits) and dt (17 bits, signed).
	localparam int TERM_W = OFFSET_W + 1;
	localparam int PROD_W = TERM_W + COUNT_W + 1;

	// Offset clamp limits as quotient magnitudes, and the clamped offsets.
	localparam logic [SUM_W-1:0]    OFS_POS_LIMIT = 40'd8388607;
	localparam logic [SUM_W-1:0]    OFS_NEG_LIMIT = 40'd8388608;
	localparam logic [OFFSET_W-1:0] OFS_MAX       = 24'h7FFFFF;
	localparam logic [OFFSET_W-1:0] OFS_MIN       = 24'h800000;

	// Saturation limits of the angle.
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
	localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

	// Request command codes; the fourth code is unused and ignored.
	typedef enum logic [CMD_W-1:0] {
		CMD_UPDATE    = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_ZERO      = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_STEP    = 1'd0,
		REG_CAL_SAMPLES = 1'd1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] MAX_STEP_RESET    = 16'd200;
	localparam logic [CFG_W-1:0] CAL_SAMPLES_RESET = 16'd500;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ACC,
		ST_DIV,
		ST_CAL_FIN,
		ST_FINISH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;     // latch the incoming request
		logic exec;        // apply the request's first step
		logic accumulate;  // add the registered product to the angle
		logic div_step;    // one restoring divide step
		logic cal_finish;  // sign, saturate and store the new offset
		logic out_load;    // move results into the output register
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             step_skip;
		logic             cal_complete;
		logic             div_last;
	} ctrl_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ghi_controller.sv -----
// ----------------------------------------------------------------------------
// ghi_controller: sequencing state machine of the gyro heading integrator.
// Owns the request and result handshakes and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ghi_controller (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire ghi_pkg::ctrl_status_t sts,
	output ghi_pkg::ctrl_cmd_t         ctl
);

	ghi_pkg::state_t state_q;
	ghi_pkg::state_t state_next;
	logic            out_valid_q;
	logic            out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ghi_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ghi_pkg::ST_IDLE: begin
				if (in_valid)
					state_next = ghi_pkg::ST_EXEC;
			end
			ghi_pkg::ST_EXEC: begin
				if (sts.cmd == ghi_pkg::CMD_UPDATE && !sts.step_skip)
					state_next = ghi_pkg::ST_ACC;
				else if (sts.cmd == ghi_pkg::CMD_CALIBRATE && sts.cal_complete)
					state_next = ghi_pkg::ST_DIV;
				else
					state_next = ghi_pkg::ST_FINISH;
			end
			ghi_pkg::ST_ACC: begin
				state_next = ghi_pkg::ST_FINISH;
			end
			ghi_pkg::ST_DIV: begin
				if (sts.div_last)
					state_next = ghi_pkg::ST_CAL_FIN;
			end
			ghi_pkg::ST_CAL_FIN: begin
				state_next = ghi_pkg::ST_FINISH;
			end
			ghi_pkg::ST_FINISH: begin
				if (out_free)
					state_next = ghi_pkg::ST_IDLE;
			end
			default: begin
				state_next = ghi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ghi_pkg::ST_IDLE:    ctl.capture    = in_valid;
			ghi_pkg::ST_EXEC:    ctl.exec       = 1'b1;
			ghi_pkg::ST_ACC:     ctl.accumulate = 1'b1;
			ghi_pkg::ST_DIV:     ctl.div_step   = 1'b1;
			ghi_pkg::ST_CAL_FIN: ctl.cal_finish = 1'b1;
			ghi_pkg::ST_FINISH:  ctl.out_load   = out_free;
			default:             ctl            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ghi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ghi_datapath.sv -----
// ----------------------------------------------------------------------------
// ghi_datapath: registers and arithmetic of the gyro heading integrator.
// Holds the angle, time, bias and calibration state, the rate multiplier,
// the serial bias divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ghi_datapath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ghi_pkg::ctrl_cmd_t                     ctl,
	output ghi_pkg::ctrl_status_t                       sts,
	input  wire logic [ghi_pkg::CMD_W-1:0]              command,
	input  wire logic [ghi_pkg::TIME_W-1:0]             time_ms,
	input  wire logic signed [ghi_pkg::RATE_W-1:0]      gyro_rate,
	input  wire logic                                   cfg_write,
	input  wire logic [ghi_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [ghi_pkg::CFG_W-1:0]              cfg_data,
	output logic signed [ghi_pkg::ANGLE_W-1:0]          angle_z,
	output logic signed [ghi_pkg::OFFSET_W-1:0]         offset_z,
	output logic                                        step_skipped,
	output logic                                        calibration_done
);

	// Captured request.
	logic [ghi_pkg::CMD_W-1:0]             cmd_q;
	logic [ghi_pkg::TIME_W-1:0]            time_q;
	logic signed [ghi_pkg::RATE_W-1:0]     rate_q;

	// Configuration.
	logic [ghi_pkg::CFG_W-1:0]             max_step_q;
	logic [ghi_pkg::CFG_W-1:0]             cal_samples_q;

	// Architectural state.
	logic signed [ghi_pkg::ANGLE_W-1:0]    angle_q;
	logic [ghi_pkg::TIME_W-1:0]            prev_time_q;
	logic signed [ghi_pkg::OFFSET_W-1:0]   offset_q;
	logic signed [ghi_pkg::SUM_W-1:0]      cal_sum_q;
	logic [ghi_pkg::COUNT_W-1:0]           cal_count_q;

	// Working registers.
	logic signed [ghi_pkg::PROD_W-1:0]     product_q;
	logic                                  skip_q;
	logic                                  done_q;
	logic                                  div_neg_q;
	logic [ghi_pkg::COUNT_W-1:0]           div_rem_q;
	logic [ghi_pkg::SUM_W-1:0]             div_quo_q;
	logic [ghi_pkg::COUNT_W-1:0]           div_den_q;
	logic [ghi_pkg::DIV_CNT_W-1:0]         div_cnt_q;

	// Output register.
	logic signed [ghi_pkg::ANGLE_W-1:0]    angle_out_q;
	logic signed [ghi_pkg::OFFSET_W-1:0]   offset_out_q;
	logic                                  skipped_out_q;
	logic                                  done_out_q;

	// Combinational terms.
	logic [ghi_pkg::TIME_W-1:0]            dt;
	logic                                  step_skip;
	logic signed [ghi_pkg::TERM_W-1:0]     term;
	logic signed [ghi_pkg::PROD_W-1:0]     mul_w;
	logic [ghi_pkg::ANGLE_W:0]             acc_sum;
	logic signed [ghi_pkg::SUM_W-1:0]      sum_next;
	logic [ghi_pkg::COUNT_W-1:0]           count_next;
	logic                                  cal_complete;
	logic [ghi_pkg::SUM_W-1:0]             sum_mag;
	logic [ghi_pkg::COUNT_W:0]             rem_shift;
	logic [ghi_pkg::COUNT_W+1:0]           rem_diff;
	logic                                  quo_bit;
	logic [ghi_pkg::OFFSET_W-1:0]          offset_new;

	// Elapsed time wraps modulo 2^32.
	assign dt        = time_q - prev_time_q;
	assign step_skip = (dt == '0) || (dt > {16'd0, max_step_q});

	// Bias-corrected rate; dt is at most 16 bits whenever the step is used.
	assign term  = {rate_q[ghi_pkg::RATE_W-1], rate_q, {ghi_pkg::FRAC_BITS{1'b0}}}
	             - {offset_q[ghi_pkg::OFFSET_W-1], offset_q};
	assign mul_w = term * $signed({1'b0, dt[ghi_pkg::COUNT_W-1:0]});

	// 65-bit sum of angle and product for saturation.
	assign acc_sum = {angle_q[ghi_pkg::ANGLE_W-1], angle_q}
	               + {{(ghi_pkg::ANGLE_W+1-ghi_pkg::PROD_W){product_q[ghi_pkg::PROD_W-1]}},
	                  product_q};

	// Calibration accumulation.
	assign sum_next     = cal_sum_q + {{(ghi_pkg::SUM_W-ghi_pkg::RATE_W){rate_q[ghi_pkg::RATE_W-1]}},
	                                   rate_q};
	assign count_next   = cal_count_q + 16'd1;
	assign cal_complete = (count_next >= cal_samples_q) || (count_next == '0);
	assign sum_mag      = sum_next[ghi_pkg::SUM_W-1] ? (40'd0 - sum_next) : sum_next;

	// One restoring divide step.
	assign rem_shift = {div_rem_q, div_quo_q[ghi_pkg::SUM_W-1]};
	assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_den_q};
	assign quo_bit   = !rem_diff[ghi_pkg::COUNT_W+1];

	// Apply the sign and clamp the quotient to the offset range.
	always_comb begin
		if (div_neg_q) begin
			if (div_quo_q > ghi_pkg::OFS_NEG_LIMIT)
				offset_new = ghi_pkg::OFS_MIN;
			else
				offset_new = 24'd0 - div_quo_q[ghi_pkg::OFFSET_W-1:0];
		end else begin
			if (div_quo_q > ghi_pkg::OFS_POS_LIMIT)
				offset_new = ghi_pkg::OFS_MAX;
			else
				offset_new = div_quo_q[ghi_pkg::OFFSET_W-1:0];
		end
	end

	assign sts.cmd          = cmd_q;
	assign sts.step_skip    = step_skip;
	assign sts.cal_complete = cal_complete;
	assign sts.div_last     = (div_cnt_q == ghi_pkg::DIV_CNT_W'(ghi_pkg::DIV_STEPS - 1));

	// Request capture, product, divider working data and output register: no reset needed.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= command;
			time_q <= time_ms;
			rate_q <= gyro_rate;
		end
		if (ctl.exec) begin
			product_q <= mul_w;
			div_neg_q <= sum_next[ghi_pkg::SUM_W-1];
			div_rem_q <= '0;
			div_quo_q <= {sum_mag[ghi_pkg::SUM_W-1-ghi_pkg::FRAC_BITS:0],
			              {ghi_pkg::FRAC_BITS{1'b0}}};
			div_den_q <= (count_next == '0) ? 16'd1 : count_next;
			div_cnt_q <= '0;
		end
		if (ctl.div_step) begin
			div_rem_q <= quo_bit ? rem_diff[ghi_pkg::COUNT_W-1:0]
			                     : rem_shift[ghi_pkg::COUNT_W-1:0];
			div_quo_q <= {div_quo_q[ghi_pkg::SUM_W-2:0], quo_bit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (ctl.out_load) begin
			angle_out_q   <= angle_q;
			offset_out_q  <= offset_q;
			skipped_out_q <= skip_q;
			done_out_q    <= done_q;
		end
	end

	// Configuration registers, architectural state and the skip and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q    <= ghi_pkg::MAX_STEP_RESET;
			cal_samples_q <= ghi_pkg::CAL_SAMPLES_RESET;
			angle_q       <= '0;
			prev_time_q   <= '0;
			offset_q      <= '0;
			cal_sum_q     <= '0;
			cal_count_q   <= '0;
			skip_q        <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ghi_pkg::REG_MAX_STEP:    max_step_q    <= cfg_data;
					ghi_pkg::REG_CAL_SAMPLES: cal_samples_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.capture) begin
				skip_q <= 1'b0;
				done_q <= 1'b0;
			end
			if (ctl.exec) begin
				case (cmd_q)
					ghi_pkg::CMD_UPDATE: begin
						prev_time_q <= time_q;
						skip_q      <= step_skip;
					end
					ghi_pkg::CMD_CALIBRATE: begin
						if (cal_complete) begin
							cal_sum_q   <= '0;
							cal_count_q <= '0;
						end else begin
							cal_sum_q   <= sum_next;
							cal_count_q <= count_next;
						end
					end
					ghi_pkg::CMD_ZERO: begin
						angle_q     <= '0;
						prev_time_q <= time_q;
					end
					default: ;
				endcase
			end
			if (ctl.accumulate) begin
				if (acc_sum[ghi_pkg::ANGLE_W] != acc_sum[ghi_pkg::ANGLE_W-1])
					angle_q <= acc_sum[ghi_pkg::ANGLE_W] ? ghi_pkg::ANGLE_MIN
					                                     : ghi_pkg::ANGLE_MAX;
				else
					angle_q <= acc_sum[ghi_pkg::ANGLE_W-1:0];
			end
			if (ctl.cal_finish) begin
				offset_q <= offset_new;
				done_q   <= 1'b1;
			end
		end
	end

	assign angle_z          = angle_out_q;
	assign offset_z         = offset_out_q;
	assign step_skipped     = skipped_out_q;
	assign calibration_done = done_out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/gyro_bias_and_heading_integrator.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_and_heading_integrator: Z-axis gyro heading integrator with bias.
// Each request passes IDLE, EXEC and FINISH; an integrated update adds ACC,
// and a completing calibration sample adds DIV, the 40-step serial bias
// divider, and CAL_FIN. A new request is taken only in IDLE, once the
// previous one has left FINISH.
// Reset: asynchronous; clears angle, time, offset and calibration state.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_and_heading_integrator (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Request channel.
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [ghi_pkg::CMD_W-1:0]              command,
	input  wire logic [ghi_pkg::TIME_W-1:0]             time_ms,
	input  wire logic signed [ghi_pkg::RATE_W-1:0]      gyro_rate,
	// Result channel.
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [ghi_pkg::ANGLE_W-1:0]          angle_z,
	output logic signed [ghi_pkg::OFFSET_W-1:0]         offset_z,
	output logic                                        step_skipped,
	output logic                                        calibration_done,
	// Configuration write port.
	input  wire logic                                   cfg_write,
	input  wire logic [ghi_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [ghi_pkg::CFG_W-1:0]              cfg_data
);

	// The controller walks each request through the datapath:
	//   an update computes the wrapping elapsed time, stores the new time and
	//   either flags the step as skipped or multiplies the bias-corrected rate
	//   by dt, then adds the registered product to the angle with saturation;
	//   a calibration sample adds into the running sum and, when the sample
	//   count is reached, runs a restoring divide of sum * 256 by the count,
	//   one quotient bit per cycle, before clamping the new offset to 24 bits;
	//   a zero request clears the angle and stores the time.
	// Results land in an output register, so a new request is taken while the
	// previous result still waits to be drained.

	ghi_pkg::ctrl_cmd_t    ctl;
	ghi_pkg::ctrl_status_t sts;

	ghi_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	ghi_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.command          (command),
		.time_ms          (time_ms),
		.gyro_rate        (gyro_rate),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.angle_z          (angle_z),
		.offset_z         (offset_z),
		.step_skipped     (step_skipped),
		.calibration_done (calibration_done)
	);

endmodule

`default_nettype wire

// ----- dv/tb_gyro_bias_and_heading_integrator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyro_bias_and_heading_integrator: self-checking bench for the heading
// integrator.
// A request driver and a result monitor run as clocked processes. Every
// accepted request is run through a bit-accurate heading and bias predictor,
// and each result is compared with the oldest prediction. A short directed
// sequence covers the field extremes and corner cases. It is followed by
// random flights of timestamped updates and calibration runs under several
// register settings, random idling on both channels and a long output hold.
// ----------------------------------------------------------------------------

module tb_gyro_bias_and_heading_integrator;

	// The fourth command code has no member in cmd_t. The block ignores it.
	localparam logic [ghi_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;

	localparam longint BIAS_CEIL  = 64'sd8388607;
	localparam longint BIAS_FLOOR = -64'sd8388608;

	// Number of cycles of the long output hold, and the drain margin at the end.
	// The margin covers the worst request latency (a completing calibration).
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct packed {
		logic [ghi_pkg::CMD_W-1:0]  cmd;
		logic [ghi_pkg::TIME_W-1:0] stamp;
		logic [ghi_pkg::RATE_W-1:0] rate;
	} gyro_request_t;

	typedef struct packed {
		logic [ghi_pkg::ANGLE_W-1:0]  angle;
		logic [ghi_pkg::OFFSET_W-1:0] offset;
		logic                         skipped;
		logic                         done;
	} heading_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Request channel.
	logic          in_valid = 1'b0;
	logic          in_stall;
	gyro_request_t offered  = '0;

	// Result channel.
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [ghi_pkg::ANGLE_W-1:0]  angle_z;
	logic signed [ghi_pkg::OFFSET_W-1:0] offset_z;
	logic                                step_skipped;
	logic                                calibration_done;

	// Register write port.
	logic                      cfg_write = 1'b0;
	ghi_pkg::cfg_reg_t         cfg_index = ghi_pkg::REG_MAX_STEP;
	logic [ghi_pkg::CFG_W-1:0] cfg_data  = '0;

	// Requests waiting to be offered, and results the predictor has promised.
	gyro_request_t   gyro_requests[$];
	heading_result_t readings_due[$];
	heading_result_t due;

	// Idle rates in percent, set by the stimulus process per phase.
	int send_gap_pct   = 37;
	int recv_stall_pct = 37;

	// The stimulus orders a long output hold by bumping hold_orders. The
	// monitor counts the hold down itself.
	int hold_orders = 0;
	int hold_served = 0;
	int hold_left   = 0;

	int mismatches = 0;

	// Timestamp the well-formed flights advance from.
	logic [ghi_pkg::TIME_W-1:0] stamp_now = '0;

	// Predictor state: the block's registers and accumulators as after reset.
	logic [ghi_pkg::CFG_W-1:0]           step_limit   = ghi_pkg::MAX_STEP_RESET;
	logic [ghi_pkg::CFG_W-1:0]           still_target = ghi_pkg::CAL_SAMPLES_RESET;
	logic signed [ghi_pkg::ANGLE_W-1:0]  heading      = '0;
	logic [ghi_pkg::TIME_W-1:0]          last_stamp   = '0;
	logic signed [ghi_pkg::OFFSET_W-1:0] bias         = '0;
	logic signed [ghi_pkg::SUM_W-1:0]    still_sum    = '0;
	logic [ghi_pkg::COUNT_W-1:0]         still_count  = '0;

	gyro_bias_and_heading_integrator uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (offered.cmd),
		.time_ms          (offered.stamp),
		.gyro_rate        (offered.rate),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.angle_z          (angle_z),
		.offset_z         (offset_z),
		.step_skipped     (step_skipped),
		.calibration_done (calibration_done),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one request to the predictor state and returns the result the
	// block must produce for it.
	function automatic heading_result_t integrate_heading(gyro_request_t req);
		heading_result_t                    res;
		logic [ghi_pkg::TIME_W-1:0]         dt;
		logic signed [ghi_pkg::TERM_W-1:0]  term;
		logic signed [ghi_pkg::ANGLE_W-1:0] prod;
		logic [ghi_pkg::ANGLE_W:0]          total;
		longint                             scaled;
		longint                             quot;
		res = '0;
		case (req.cmd)
			ghi_pkg::CMD_UPDATE: begin
				// Elapsed time wraps with the timestamp; the new time is kept
				// whether or not the step is used.
				dt = req.stamp - last_stamp;
				last_stamp = req.stamp;
				if (dt == '0 || dt > {16'd0, step_limit}) begin
					res.skipped = 1'b1;
				end else begin
					term = $signed({req.rate, {ghi_pkg::FRAC_BITS{1'b0}}}) - bias;
					// A 25-bit term times a 32-bit step stays well inside 64 bits,
					// so only the sum with the angle can saturate.
					prod = term * $signed({1'b0, dt});
					total = {heading[ghi_pkg::ANGLE_W-1], heading}
					      + {prod[ghi_pkg::ANGLE_W-1], prod};
					if (total[ghi_pkg::ANGLE_W] != total[ghi_pkg::ANGLE_W-1])
						heading = total[ghi_pkg::ANGLE_W] ? ghi_pkg::ANGLE_MIN
							: ghi_pkg::ANGLE_MAX;
					else
						heading = total[ghi_pkg::ANGLE_W-1:0];
				end
			end
			ghi_pkg::CMD_CALIBRATE: begin
				still_sum   = still_sum + $signed(req.rate);
				still_count = still_count + 1'b1;
				// A target of zero completes on every sample. A target lowered
				// below the running count completes on the next sample.
				if (still_count >= still_target || still_count == '0) begin
					if (still_count == '0)
						still_count = ghi_pkg::COUNT_W'(1);
					scaled = still_sum;
					scaled = scaled * (64'sd1 <<< ghi_pkg::FRAC_BITS);
					quot   = scaled / longint'(still_count);
					if (quot > BIAS_CEIL)
						quot = BIAS_CEIL;
					else if (quot < BIAS_FLOOR)
						quot = BIAS_FLOOR;
					bias        = quot[ghi_pkg::OFFSET_W-1:0];
					still_sum   = '0;
					still_count = '0;
					res.done    = 1'b1;
				end
			end
			ghi_pkg::CMD_ZERO: begin
				heading    = '0;
				last_stamp = req.stamp;
			end
			default: begin
			end
		endcase
		res.angle  = heading;
		res.offset = bias;
		return res;
	endfunction

	// Request driver. A request is taken at an edge with valid high and stall
	// low; its prediction is recorded at that edge. The payload only moves on
	// once the current request has gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			offered  <= '0;
		end else begin
			if (in_valid && !in_stall)
				readings_due.push_back(integrate_heading(offered));
			if (!in_valid || !in_stall) begin
				if (gyro_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					offered  <= gyro_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Checks each accepted result against the oldest
	// prediction and decides the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			hold_left   <= 0;
			hold_served <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatches++;
				end else begin
					due = readings_due.pop_front();
					if (angle_z !== due.angle) begin
						$error("angle_z expected %0d got %0d",
							$signed(due.angle), angle_z);
						mismatches++;
					end
					if (offset_z !== due.offset) begin
						$error("offset_z expected %0d got %0d",
							$signed(due.offset), offset_z);
						mismatches++;
					end
					if (step_skipped !== due.skipped) begin
						$error("step_skipped expected %0d got %0d",
							due.skipped, step_skipped);
						mismatches++;
					end
					if (calibration_done !== due.done) begin
						$error("calibration_done expected %0d got %0d",
							due.done, calibration_done);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_served != hold_orders) begin
				hold_served <= hold_orders;
				hold_left   <= HOLD_CYCLES;
				out_stall   <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic queue_request(logic [ghi_pkg::CMD_W-1:0] cmd,
		logic [ghi_pkg::TIME_W-1:0] stamp, logic [ghi_pkg::RATE_W-1:0] rate);
		gyro_request_t req;
		req.cmd   = cmd;
		req.stamp = stamp;
		req.rate  = rate;
		gyro_requests.push_back(req);
	endtask

	// Holds the sender back until every outstanding request has its result.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (gyro_requests.size() != 0 || in_valid || readings_due.size() != 0);
	endtask

	// Register writes happen only while the block is idle, so the predictor's
	// copy can follow at once.
	task automatic set_register(ghi_pkg::cfg_reg_t idx, logic [ghi_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == ghi_pkg::REG_MAX_STEP)
			step_limit = value;
		else
			still_target = value;
		@(negedge clk);
	endtask

	// Mostly a still sensor near a small bias, sometimes any value at all.
	function automatic logic [ghi_pkg::RATE_W-1:0] pick_rate();
		if ($urandom_range(99) < 70)
			return ghi_pkg::RATE_W'($urandom_range(400)) - ghi_pkg::RATE_W'(200);
		return ghi_pkg::RATE_W'($urandom);
	endfunction

	// Time between updates: mostly a usable step, now and then a repeated
	// timestamp or a gap beyond the step limit.
	function automatic logic [ghi_pkg::TIME_W-1:0] pick_lag();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return ghi_pkg::TIME_W'(step_limit) + 1 + $urandom_range(1000);
		if (step_limit == '0)
			return 1 + $urandom_range(100);
		return 1 + $urandom_range(step_limit - 1);
	endfunction

	// A random flight: well-formed update and calibration traffic with noise.
	task automatic queue_flight(int count);
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				stamp_now = stamp_now + pick_lag();
				queue_request(ghi_pkg::CMD_UPDATE, stamp_now, pick_rate());
			end else if (pick < 75) begin
				queue_request(ghi_pkg::CMD_CALIBRATE, $urandom, pick_rate());
			end else if (pick < 82) begin
				stamp_now = stamp_now + $urandom_range(1000);
				queue_request(ghi_pkg::CMD_ZERO, stamp_now, pick_rate());
			end else if (pick < 86) begin
				queue_request(CMD_IGNORED, $urandom, ghi_pkg::RATE_W'($urandom));
			end else begin
				stamp_now = $urandom;
				queue_request(ghi_pkg::CMD_W'($urandom_range(3)), stamp_now,
					ghi_pkg::RATE_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, starting from the reset registers (200 ms, 500 samples).
		// A first update at the reset time is a zero step and is skipped.
		queue_request(ghi_pkg::CMD_UPDATE, 32'd0, 16'd100);
		queue_request(ghi_pkg::CMD_UPDATE, 32'd5, 16'h7FFF);
		// Exactly the step limit is still integrated; one more is dropped.
		queue_request(ghi_pkg::CMD_UPDATE, 32'd205, 16'h8000);
		queue_request(ghi_pkg::CMD_UPDATE, 32'd406, 16'd1);
		// Zeroing near the top of the timestamp range, then a wrapping update.
		queue_request(ghi_pkg::CMD_ZERO, 32'hFFFF_FFF0, 16'd0);
		queue_request(ghi_pkg::CMD_UPDATE, 32'h0000_0010, 16'hFFFF);
		queue_request(CMD_IGNORED, 32'hFFFF_FFFF, 16'h5A5A);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'd1000);
		wait_idle();

		// Target dropped to one below the running count: completes dividing by
		// two. Then the full-scale negative and positive bias.
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd1);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'h8000);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'h8000);
		queue_request(ghi_pkg::CMD_UPDATE, 32'h0000_0011, 16'h7FFF);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'h7FFF);
		wait_idle();

		// A negative average that truncates toward zero after a lowered target.
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd10);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'hFFFF);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'hFFFE);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'd0);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'd0);
		wait_idle();
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd2);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'd0);
		wait_idle();

		// A target of zero behaves as one.
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd0);
		queue_request(ghi_pkg::CMD_CALIBRATE, 32'd0, 16'd7);
		wait_idle();

		// A step limit of zero drops every update.
		set_register(ghi_pkg::REG_MAX_STEP, 16'd0);
		queue_request(ghi_pkg::CMD_UPDATE, 32'h0000_0020, 16'd5);
		wait_idle();

		// The largest step limit: taken at the limit, dropped one past it.
		set_register(ghi_pkg::REG_MAX_STEP, 16'hFFFF);
		stamp_now = 32'h0000_0020 + 32'd65535;
		queue_request(ghi_pkg::CMD_UPDATE, stamp_now, 16'h8000);
		stamp_now = stamp_now + 32'd65536;
		queue_request(ghi_pkg::CMD_UPDATE, stamp_now, 16'd3);
		wait_idle();

		// The smallest nonzero step limit.
		set_register(ghi_pkg::REG_MAX_STEP, 16'd1);
		stamp_now = stamp_now + 32'd1;
		queue_request(ghi_pkg::CMD_UPDATE, stamp_now, 16'h7FFF);
		stamp_now = stamp_now + 32'd2;
		queue_request(ghi_pkg::CMD_UPDATE, stamp_now, 16'd9);
		wait_idle();

		// Random flights. Each phase waits for every result before the
		// registers change.
		set_register(ghi_pkg::REG_MAX_STEP, 16'd200);
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd4);
		queue_flight(150);
		wait_idle();

		// A long stretch with no idling on either side, at the largest settings.
		set_register(ghi_pkg::REG_MAX_STEP, 16'hFFFF);
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'hFFFF);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		queue_flight(100);
		wait_idle();

		// Back-pressure: the receiver holds off while the sender keeps offering,
		// so the block fills up and stalls its request side.
		set_register(ghi_pkg::REG_MAX_STEP, 16'd50);
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd3);
		recv_stall_pct = 37;
		hold_orders++;
		queue_flight(100);
		wait_idle();

		set_register(ghi_pkg::REG_MAX_STEP, 16'd1000);
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd1);
		send_gap_pct = 37;
		queue_flight(150);
		wait_idle();

		set_register(ghi_pkg::REG_MAX_STEP, 16'd20);
		set_register(ghi_pkg::REG_CAL_SAMPLES, 16'd7);
		queue_flight(100);
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && readings_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
